/* rtl/core/fvu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvu_pkg: shared types and constants of the flocking velocity update unit
// Q4.20 word format, payload structs, agent record and saturation helpers.
// ----------------------------------------------------------------------------
package fvu_pkg;

	localparam int FRAC_BITS  = 20;
	localparam int WORD_BITS  = FRAC_BITS + 4;
	localparam int SPEED_BITS = FRAC_BITS;
	localparam int IDX_BITS   = 6;
	localparam int CNT_BITS   = 7;
	localparam int D2_BITS    = 2 * WORD_BITS;
	localparam int ROOT_BITS  = WORD_BITS;
	localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
	localparam int DEN_BITS   = 32;
	localparam int MUL_BITS   = 32;
	localparam int Q_BITS     = D2_BITS - FRAC_BITS;
	localparam int K_BITS     = 28;

	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint TENTH = (ONE + 5) / 10;
	localparam longint ATT_K = (4 * ONE + 5) / 10;
	localparam longint REP_K = 5 * ONE;
	localparam longint COH_K = ONE;
	localparam longint MILLI = (ONE + 500) / 1000;

	localparam logic [NUM_BITS-1:0] ATT_NUM   = NUM_BITS'(ATT_K * ONE);
	localparam logic [NUM_BITS-1:0] REP_NUM   = NUM_BITS'(REP_K * ONE);
	localparam logic [NUM_BITS-1:0] COH_NUM   = NUM_BITS'(COH_K * ONE);
	localparam logic [DEN_BITS-1:0] TENTH_DEN = DEN_BITS'(TENTH);
	localparam logic signed [MUL_BITS-1:0] MILLI_MUL = MUL_BITS'(MILLI);

	localparam logic [CNT_BITS-1:0] AGENT_COUNT_RST = CNT_BITS'(64);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic                  func;
		logic [IDX_BITS-1:0]   agent_index;
		word_t                 load_pos_x;
		word_t                 load_pos_y;
		word_t                 load_vel_x;
		word_t                 load_vel_y;
		logic [SPEED_BITS-1:0] load_speed;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] out_index;
		word_t               out_pos_x;
		word_t               out_pos_y;
		word_t               out_vel_x;
		word_t               out_vel_y;
		logic                last;
	} out_item_t;

	typedef struct packed {
		word_t                 pos_x;
		word_t                 pos_y;
		word_t                 vel_x;
		word_t                 vel_y;
		logic [SPEED_BITS-1:0] speed;
	} agent_rec_t;

	// clamp a wide signed value to the word range
	function automatic word_t sat_word(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return word_t'(hi);
		end else if (v < lo) begin
			return word_t'(lo);
		end
		return word_t'(v);
	endfunction

	function automatic logic [WORD_BITS-1:0] mag_word(input word_t v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

endpackage

/* rtl/core/fvu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvu_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fvu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/flocking_velocity_update_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flocking_velocity_update_unit: flocking update over an agent store
// Loads write agent records; a step runs the pairwise pass and the
// normalize/advance pass over a shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
// channel | signals                     | direction | transaction
// in      | in_valid/in_ready/in_data   | input     | load one agent or run a step
// out     | out_valid/out_ready/out_data| output    | one updated agent
// cfg     | cfg_valid/cfg_ready/cfg_data| input     | agent_count write
//
// Load writes one agent record. A step takes less time where pairs coincide
// or a velocity is zero; each pair costs one 24-step square root and five
// 44-step divisions on the shared units.
// Reset sets agent_count to 64; the agent store is undefined until loaded.
// out_ready low while an agent is still pending holds the sequencer at the emit of the next agent.
// in_ready is high only while no step is running.
// ----------------------------------------------------------------------------
module flocking_velocity_update_unit #(
	parameter int MAX_AGENTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fvu_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fvu_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fvu_pkg::CNT_BITS-1:0]    cfg_data
);

	localparam int IW       = $clog2(MAX_AGENTS);
	localparam int W        = fvu_pkg::WORD_BITS;
	localparam int F        = fvu_pkg::FRAC_BITS;
	localparam int NB       = fvu_pkg::NUM_BITS;
	localparam int DB       = fvu_pkg::DEN_BITS;
	localparam int RB       = fvu_pkg::ROOT_BITS;
	localparam int D2B      = fvu_pkg::D2_BITS;
	localparam int QB       = fvu_pkg::Q_BITS;
	localparam int KB       = fvu_pkg::K_BITS;
	localparam int DIV_CW   = $clog2(NB + 1);
	localparam int SQ_CW    = $clog2(RB + 1);

	typedef enum logic [5:0] {
		S_IDLE,
		P_RDI, P_LDI, P_RDJ, P_DIFF, P_SQX, P_SQY, P_D2, P_SQRT,
		P_DUX, P_DUY, P_DATT, P_DREP, P_DCOH, P_KM, P_KC,
		P_AX, P_BX, P_AY, P_BY, P_NXJ, P_WB,
		Q_RD, Q_LD, Q_M1, Q_M2, Q_M3, Q_M4, Q_M5, Q_M6, Q_M7,
		Q_VV, Q_V2, Q_LEN, Q_SQ, Q_NX, Q_NY, Q_PX, Q_PY, Q_OUT
	} state_t;

	state_t state_q;

	logic [fvu_pkg::CNT_BITS-1:0] agent_count_q;
	logic [IW-1:0] i_q, j_q, last_q;
	logic [IW-1:0] step_last;

	fvu_pkg::word_t pix_q, piy_q, vix_q, viy_q, vjx_q, vjy_q;
	fvu_pkg::word_t dx_q, dy_q, ux_q, uy_q, km_q, kc_q, ax_q, t1_q, t2_q;
	logic [fvu_pkg::SPEED_BITS-1:0] spd_q;
	logic [D2B-1:0] tmp_q;
	logic [QB-1:0]  q_q;
	logic [RB-1:0]  dist_q;
	logic [KB-1:0]  att_q, rep_q, coh_q;

	logic signed [fvu_pkg::MUL_BITS-1:0] mul_a_q, mul_b_q;
	logic signed [63:0] mul_p, mul_sh;

	logic          div_go_q, div_neg_q, div_go_d;
	logic [NB-1:0] div_num_q;
	logic [DB-1:0] div_den_q;
	logic          div_busy_q, div_done;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [NB-1:0] dv_num_q;
	logic [DB:0]   dv_rem_q;
	logic [DB-1:0] dv_den_q;
	logic [DB:0]   dv_rem_sh;
	logic          dv_ge;
	logic signed [NB:0] div_res;

	logic           sq_go_q, sq_go_d;
	logic [D2B-1:0] sq_arg_q;
	logic           sq_busy_q, sq_done;
	logic [SQ_CW-1:0] sq_cnt_q;
	logic [D2B-1:0] sq_rad_q;
	logic [RB+2:0]  sq_rem_q;
	logic [RB-1:0]  sq_root_q;
	logic [RB+2:0]  sq_rem_nx, sq_trial;
	logic           sq_ge;

	logic [D2B-1:0] sq_sum;
	logic signed [KB:0] k_diff;
	logic [DB-1:0]  q_den, q9_den;
	fvu_pkg::word_t piy_new;
	logic           out_free;
	logic           emit;

	logic                ram_we, ram_re;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	fvu_pkg::agent_rec_t ram_wdata, ram_rdata;

	fvu_ram #(
		.WIDTH($bits(fvu_pkg::agent_rec_t)),
		.DEPTH(MAX_AGENTS)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign emit      = (state_q == Q_OUT) && out_free;

	assign mul_p  = mul_a_q * mul_b_q;
	assign mul_sh = mul_p >>> F;

	assign sq_sum  = tmp_q + mul_p[D2B-1:0];
	assign k_diff  = $signed({1'b0, rep_q}) - $signed({1'b0, att_q});
	assign q_den   = DB'(q_q) + fvu_pkg::TENTH_DEN;
	assign q9_den  = (DB'(q_q) << 3) + DB'(q_q) + fvu_pkg::TENTH_DEN;
	assign piy_new = fvu_pkg::sat_word(64'(piy_q) + mul_sh);

	assign step_last = (int'(agent_count_q) > MAX_AGENTS) ? IW'(MAX_AGENTS - 1)
		: IW'(int'(agent_count_q) - 1);

	// store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_data.func == fvu_pkg::FUNC_LOAD
						&& int'(in_data.agent_index) < MAX_AGENTS) begin
					ram_we          = 1'b1;
					ram_waddr       = IW'(in_data.agent_index);
					ram_wdata.pos_x = in_data.load_pos_x;
					ram_wdata.pos_y = in_data.load_pos_y;
					ram_wdata.vel_x = in_data.load_vel_x;
					ram_wdata.vel_y = in_data.load_vel_y;
					ram_wdata.speed = in_data.load_speed;
				end
			end
			P_RDI, Q_RD: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			P_RDJ: begin
				ram_re    = (j_q != i_q);
				ram_raddr = j_q;
			end
			P_WB: begin
				ram_we          = 1'b1;
				ram_waddr       = i_q;
				ram_wdata.pos_x = pix_q;
				ram_wdata.pos_y = piy_q;
				ram_wdata.vel_x = vix_q;
				ram_wdata.vel_y = viy_q;
				ram_wdata.speed = spd_q;
			end
			Q_OUT: begin
				ram_we          = out_free;
				ram_waddr       = i_q;
				ram_wdata.pos_x = pix_q;
				ram_wdata.pos_y = piy_new;
				ram_wdata.vel_x = vix_q;
				ram_wdata.vel_y = viy_q;
				ram_wdata.speed = spd_q;
			end
			default: ;
		endcase
	end

	// start pulses for the shared root and divider
	always_comb begin
		div_go_d = 1'b0;
		sq_go_d  = 1'b0;
		unique case (state_q)
			P_D2:   sq_go_d = (sq_sum != '0);
			Q_LEN:  sq_go_d = 1'b1;
			P_SQRT: div_go_d = sq_done;
			P_DUX, P_DUY, P_DATT, P_DREP, Q_NX: div_go_d = div_done;
			Q_SQ:   div_go_d = sq_done && (sq_root_q != '0);
			default: ;
		endcase
	end

	// divider: restoring, one quotient bit per cycle, magnitudes only
	assign dv_rem_sh = {dv_rem_q[DB-1:0], dv_num_q[NB-1]};
	assign dv_ge     = dv_rem_sh >= {1'b0, dv_den_q};
	assign div_done  = !div_busy_q && !div_go_q;
	assign div_res   = div_neg_q ? -$signed({1'b0, dv_num_q}) : $signed({1'b0, dv_num_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (div_go_q) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= DIV_CW'(NB);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - DIV_CW'(1);
			if (div_cnt_q == DIV_CW'(1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_go_q) begin
			dv_num_q <= div_num_q;
			dv_den_q <= div_den_q;
			dv_rem_q <= '0;
		end else if (div_busy_q) begin
			dv_rem_q <= dv_ge ? dv_rem_sh - {1'b0, dv_den_q} : dv_rem_sh;
			dv_num_q <= {dv_num_q[NB-2:0], dv_ge};
		end
	end

	// square root: two radicand bits per cycle
	assign sq_rem_nx = {sq_rem_q[RB:0], sq_rad_q[D2B-1 -: 2]};
	assign sq_trial  = {1'b0, sq_root_q, 2'b01};
	assign sq_ge     = sq_rem_nx >= sq_trial;
	assign sq_done   = !sq_busy_q && !sq_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (sq_go_q) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= SQ_CW'(RB);
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - SQ_CW'(1);
			if (sq_cnt_q == SQ_CW'(1)) begin
				sq_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_go_q) begin
			sq_rad_q  <= sq_arg_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_rad_q  <= sq_rad_q << 2;
			sq_rem_q  <= sq_ge ? sq_rem_nx - sq_trial : sq_rem_nx;
			sq_root_q <= {sq_root_q[RB-2:0], sq_ge};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			agent_count_q <= fvu_pkg::AGENT_COUNT_RST;
			out_valid     <= 1'b0;
			div_go_q      <= 1'b0;
			sq_go_q       <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			last_q        <= '0;
		end else begin
			div_go_q <= div_go_d;
			sq_go_q  <= sq_go_d;
			if (cfg_valid) begin
				agent_count_q <= cfg_data;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.func == fvu_pkg::FUNC_STEP
							&& agent_count_q != '0) begin
						last_q  <= step_last;
						i_q     <= '0;
						state_q <= P_RDI;
					end
				end
				P_RDI: state_q <= P_LDI;
				P_LDI: begin
					pix_q   <= ram_rdata.pos_x;
					piy_q   <= ram_rdata.pos_y;
					vix_q   <= ram_rdata.vel_x;
					viy_q   <= ram_rdata.vel_y;
					spd_q   <= ram_rdata.speed;
					j_q     <= '0;
					state_q <= P_RDJ;
				end
				P_RDJ: state_q <= (j_q == i_q) ? P_NXJ : P_DIFF;
				P_DIFF: begin
					dx_q    <= fvu_pkg::sat_word(64'(pix_q) - 64'(ram_rdata.pos_x));
					dy_q    <= fvu_pkg::sat_word(64'(piy_q) - 64'(ram_rdata.pos_y));
					vjx_q   <= ram_rdata.vel_x;
					vjy_q   <= ram_rdata.vel_y;
					state_q <= P_SQX;
				end
				P_SQX: begin
					mul_a_q <= 32'(dx_q);
					mul_b_q <= 32'(dx_q);
					state_q <= P_SQY;
				end
				P_SQY: begin
					tmp_q   <= mul_p[D2B-1:0];
					mul_a_q <= 32'(dy_q);
					mul_b_q <= 32'(dy_q);
					state_q <= P_D2;
				end
				P_D2: begin
					if (sq_sum == '0) begin
						state_q <= P_NXJ;   // coincident pair
					end else begin
						sq_arg_q <= sq_sum;
						q_q      <= sq_sum[D2B-1:F];
						state_q  <= P_SQRT;
					end
				end
				P_SQRT: begin
					if (sq_done) begin
						dist_q    <= sq_root_q;
						div_neg_q <= dx_q[W-1];
						div_num_q <= {fvu_pkg::mag_word(dx_q), F'(0)};
						div_den_q <= DB'(sq_root_q);
						state_q   <= P_DUX;
					end
				end
				P_DUX: begin
					if (div_done) begin
						ux_q      <= fvu_pkg::sat_word(64'(div_res));
						div_neg_q <= dy_q[W-1];
						div_num_q <= {fvu_pkg::mag_word(dy_q), F'(0)};
						div_den_q <= DB'(dist_q);
						state_q   <= P_DUY;
					end
				end
				P_DUY: begin
					if (div_done) begin
						uy_q      <= fvu_pkg::sat_word(64'(div_res));
						div_neg_q <= 1'b0;
						div_num_q <= fvu_pkg::ATT_NUM;
						div_den_q <= q_den;
						state_q   <= P_DATT;
					end
				end
				P_DATT: begin
					if (div_done) begin
						att_q     <= dv_num_q[KB-1:0];
						div_num_q <= fvu_pkg::REP_NUM;
						div_den_q <= q9_den;
						state_q   <= P_DREP;
					end
				end
				P_DREP: begin
					if (div_done) begin
						rep_q     <= dv_num_q[KB-1:0];
						div_num_q <= fvu_pkg::COH_NUM;
						div_den_q <= q_den;
						state_q   <= P_DCOH;
					end
				end
				P_DCOH: begin
					if (div_done) begin
						coh_q   <= dv_num_q[KB-1:0];
						mul_a_q <= 32'(k_diff);
						mul_b_q <= fvu_pkg::MILLI_MUL;
						state_q <= P_KM;
					end
				end
				P_KM: begin
					km_q    <= mul_sh[W-1:0];
					mul_a_q <= $signed({{(32 - KB){1'b0}}, coh_q});
					mul_b_q <= fvu_pkg::MILLI_MUL;
					state_q <= P_KC;
				end
				P_KC: begin
					kc_q    <= mul_sh[W-1:0];
					mul_a_q <= 32'(ux_q);
					mul_b_q <= 32'(km_q);
					state_q <= P_AX;
				end
				P_AX: begin
					ax_q    <= mul_sh[W-1:0];
					mul_a_q <= 32'(vjx_q);
					mul_b_q <= 32'(kc_q);
					state_q <= P_BX;
				end
				P_BX: begin
					vix_q   <= fvu_pkg::sat_word(64'(vix_q) + 64'(ax_q) + mul_sh);
					mul_a_q <= 32'(uy_q);
					mul_b_q <= 32'(km_q);
					state_q <= P_AY;
				end
				P_AY: begin
					ax_q    <= mul_sh[W-1:0];
					mul_a_q <= 32'(vjy_q);
					mul_b_q <= 32'(kc_q);
					state_q <= P_BY;
				end
				P_BY: begin
					viy_q   <= fvu_pkg::sat_word(64'(viy_q) + 64'(ax_q) + mul_sh);
					state_q <= P_NXJ;
				end
				P_NXJ: begin
					if (j_q == last_q) begin
						state_q <= P_WB;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= P_RDJ;
					end
				end
				P_WB: begin
					if (i_q == last_q) begin
						i_q     <= '0;
						state_q <= Q_RD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= P_RDI;
					end
				end
				Q_RD: state_q <= Q_LD;
				Q_LD: begin
					pix_q   <= ram_rdata.pos_x;
					piy_q   <= ram_rdata.pos_y;
					vix_q   <= ram_rdata.vel_x;
					viy_q   <= ram_rdata.vel_y;
					spd_q   <= ram_rdata.speed;
					state_q <= Q_M1;
				end
				Q_M1: begin
					mul_a_q <= 32'(pix_q);
					mul_b_q <= 32'(pix_q);
					state_q <= Q_M2;
				end
				Q_M2: begin
					t1_q    <= fvu_pkg::sat_word(mul_sh);
					mul_a_q <= 32'(piy_q);
					mul_b_q <= 32'(piy_q);
					state_q <= Q_M3;
				end
				Q_M3: begin
					t2_q    <= fvu_pkg::sat_word(mul_sh);
					mul_a_q <= 32'(t1_q);
					mul_b_q <= 32'(t1_q);
					state_q <= Q_M4;
				end
				Q_M4: begin
					t1_q    <= fvu_pkg::sat_word(mul_sh);
					mul_a_q <= 32'(t2_q);
					mul_b_q <= 32'(t2_q);
					state_q <= Q_M5;
				end
				Q_M5: begin
					t2_q    <= fvu_pkg::sat_word(mul_sh);
					mul_a_q <= 32'(t1_q);
					mul_b_q <= 32'(pix_q);
					state_q <= Q_M6;
				end
				Q_M6: begin
					vix_q   <= fvu_pkg::sat_word(64'(vix_q)
						- 64'(fvu_pkg::sat_word(mul_sh)));
					mul_a_q <= 32'(t2_q);
					mul_b_q <= 32'(piy_q);
					state_q <= Q_M7;
				end
				Q_M7: begin
					viy_q   <= fvu_pkg::sat_word(64'(viy_q)
						- 64'(fvu_pkg::sat_word(mul_sh)));
					state_q <= Q_VV;
				end
				Q_VV: begin
					mul_a_q <= 32'(vix_q);
					mul_b_q <= 32'(vix_q);
					state_q <= Q_V2;
				end
				Q_V2: begin
					tmp_q   <= mul_p[D2B-1:0];
					mul_a_q <= 32'(viy_q);
					mul_b_q <= 32'(viy_q);
					state_q <= Q_LEN;
				end
				Q_LEN: begin
					sq_arg_q <= sq_sum;
					state_q  <= Q_SQ;
				end
				Q_SQ: begin
					if (sq_done) begin
						dist_q <= sq_root_q;
						if (sq_root_q == '0) begin
							state_q <= Q_PX;   // zero velocity stays zero
						end else begin
							div_neg_q <= vix_q[W-1];
							div_num_q <= {fvu_pkg::mag_word(vix_q), F'(0)};
							div_den_q <= DB'(sq_root_q);
							state_q   <= Q_NX;
						end
					end
				end
				Q_NX: begin
					if (div_done) begin
						vix_q     <= fvu_pkg::sat_word(64'(div_res));
						div_neg_q <= viy_q[W-1];
						div_num_q <= {fvu_pkg::mag_word(viy_q), F'(0)};
						div_den_q <= DB'(dist_q);
						state_q   <= Q_NY;
					end
				end
				Q_NY: begin
					if (div_done) begin
						viy_q   <= fvu_pkg::sat_word(64'(div_res));
						state_q <= Q_PX;
					end
				end
				Q_PX: begin
					mul_a_q <= 32'(vix_q);
					mul_b_q <= $signed({{(32 - fvu_pkg::SPEED_BITS){1'b0}}, spd_q});
					state_q <= Q_PY;
				end
				Q_PY: begin
					pix_q   <= fvu_pkg::sat_word(64'(pix_q) + mul_sh);
					mul_a_q <= 32'(viy_q);
					state_q <= Q_OUT;
				end
				Q_OUT: begin
					if (out_free) begin
						out_data.out_index <= fvu_pkg::IDX_BITS'(i_q);
						out_data.out_pos_x <= pix_q;
						out_data.out_pos_y <= piy_new;
						out_data.out_vel_x <= vix_q;
						out_data.out_vel_y <= viy_q;
						out_data.last      <= (i_q == last_q);
						if (i_q == last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= Q_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
